/* src/cbtm_pkg.sv */
// cbtm_pkg: shared types, frame constants and the tone curve for the cross blur tone map unit
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps

package cbtm_pkg;

    localparam int FRAME_WIDTH  = 480;
    localparam int FRAME_HEIGHT = 360;

    localparam int COL_W = $clog2(FRAME_WIDTH);
    localparam int ROW_W = $clog2(FRAME_HEIGHT);

    localparam int LEVEL_W     = 16;
    localparam int WEIGHT_W    = 8;
    localparam int TONE_SIZE   = 1024;
    localparam int TONE_MAX    = TONE_SIZE - 1;
    localparam int TONE_ADDR_W = $clog2(TONE_SIZE);
    localparam int TONE_W      = 8;
    localparam int BLUR_W      = 19;

    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = WEIGHT_W;

    localparam logic [CFG_INDEX_W-1:0] REG_CENTER_WEIGHT = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] REG_SIDE_WEIGHT   = 1'b1;

    localparam logic [WEIGHT_W-1:0] CENTER_WEIGHT_RESET = 8'd133;
    localparam logic [WEIGHT_W-1:0] SIDE_WEIGHT_RESET   = 8'd31;

    typedef struct packed {
        logic [LEVEL_W-1:0] red;
        logic [LEVEL_W-1:0] green;
        logic [LEVEL_W-1:0] blue;
    } pixel_t;

    // one line buffer entry: row above and current row at one column
    typedef struct packed {
        pixel_t upper;
        pixel_t middle;
    } line_entry_t;

    typedef logic [TONE_W-1:0] tone_table_t [TONE_SIZE];

    // 255*(1-exp(-i*5.2/1024)), exp built from a truncated series in fixed point
    function automatic tone_table_t build_tone_table();
        logic [63:0] t0;
        logic [63:0] t1;
        logic [63:0] t2;
        logic [63:0] t3;
        logic [63:0] t4;
        logic [63:0] e48;
        logic [63:0] e32;
        logic [63:0] p;
        tone_table_t tab;
        t0  = 64'd1 << 48;
        t1  = t0 * 64'd13 / 64'd2560;
        t2  = t1 * 64'd13 / 64'd5120;
        t3  = t2 * 64'd13 / 64'd7680;
        t4  = t3 * 64'd13 / 64'd10240;
        e48 = t0 - t1 + t2 - t3 + t4;
        e32 = (e48 + (64'd1 << 15)) >> 16;
        p   = 64'd1 << 32;
        for (int i = 0; i < TONE_SIZE; i++)
        begin
            tab[i] = TONE_W'((64'd255 * ((64'd1 << 32) - p)) >> 32);
            p      = (p * e32 + (64'd1 << 31)) >> 32;
        end
        return tab;
    endfunction

    localparam tone_table_t TONE_TABLE = build_tone_table();

    function automatic logic [TONE_ADDR_W-1:0] sat_tone(input logic [BLUR_W-1:0] v);
        logic [TONE_ADDR_W-1:0] r;
        if (v > BLUR_W'(TONE_MAX))
            r = TONE_ADDR_W'(TONE_MAX);
        else
            r = v[TONE_ADDR_W-1:0];
        return r;
    endfunction

endpackage

/* src/cbtm_line_buf.sv */
// cbtm_line_buf: two-row line buffer, one write and two registered reads per cycle
// depends on cbtm_pkg; a read at the address written on the same edge gets the new entry
`timescale 1ns / 1ps

module cbtm_line_buf
    import cbtm_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              rd_en,
    input  logic [COL_W-1:0]  rd_addr_a,
    input  logic [COL_W-1:0]  rd_addr_b,
    input  logic              wr_en,
    input  logic [COL_W-1:0]  wr_addr,
    input  line_entry_t       wr_data,
    output line_entry_t       rd_data_a,
    output pixel_t            rd_data_b
);

    line_entry_t mem [FRAME_WIDTH];
    line_entry_t mem_a_reg;
    line_entry_t mem_b_reg;
    line_entry_t fwd_reg;
    logic        hit_a_reg;
    logic        hit_b_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        if (rd_en)
        begin
            mem_a_reg <= mem[rd_addr_a];
            mem_b_reg <= mem[rd_addr_b];
            fwd_reg   <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hit_a_reg <= 1'b0;
            hit_b_reg <= 1'b0;
        end
        else if (rd_en)
        begin
            hit_a_reg <= wr_en && (wr_addr == rd_addr_a);
            hit_b_reg <= wr_en && (wr_addr == rd_addr_b);
        end
    end

    assign rd_data_a = hit_a_reg ? fwd_reg : mem_a_reg;
    assign rd_data_b = hit_b_reg ? fwd_reg.middle : mem_b_reg.middle;

endmodule

/* src/cbtm_tone_rom.sv */
// cbtm_tone_rom: tone curve rom for one channel, two registered read ports
// depends on cbtm_pkg for the table contents
`timescale 1ns / 1ps

module cbtm_tone_rom
    import cbtm_pkg::*;
(
    input  logic                   clk,
    input  logic                   rd_en,
    input  logic [TONE_ADDR_W-1:0] addr_a,
    input  logic [TONE_ADDR_W-1:0] addr_b,
    output logic [TONE_W-1:0]      data_a,
    output logic [TONE_W-1:0]      data_b
);

    logic [TONE_W-1:0] data_a_reg;
    logic [TONE_W-1:0] data_b_reg;

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            data_a_reg <= TONE_TABLE[addr_a];
            data_b_reg <= TONE_TABLE[addr_b];
        end
    end

    assign data_a = data_a_reg;
    assign data_b = data_b_reg;

endmodule

/* src/cbtm_blur_lane.sv */
// cbtm_blur_lane: five-point weighted sum of one channel, saturated to a tone rom address
// depends on cbtm_pkg
`timescale 1ns / 1ps

module cbtm_blur_lane
    import cbtm_pkg::*;
(
    input  logic [WEIGHT_W-1:0]    center_weight,
    input  logic [WEIGHT_W-1:0]    side_weight,
    input  logic                   interior,
    input  logic [LEVEL_W-1:0]     center,
    input  logic [LEVEL_W-1:0]     left,
    input  logic [LEVEL_W-1:0]     right,
    input  logic [LEVEL_W-1:0]     up,
    input  logic [LEVEL_W-1:0]     down,
    output logic [TONE_ADDR_W-1:0] tone_addr
);

    logic [LEVEL_W+1:0]            sides;
    logic [LEVEL_W+WEIGHT_W-1:0]   prod_c;
    logic [LEVEL_W+WEIGHT_W+1:0]   prod_s;
    logic [LEVEL_W+WEIGHT_W+2:0]   sum;
    logic [BLUR_W-1:0]             value;

    always_comb
    begin
        sides  = (LEVEL_W+2)'(left) + (LEVEL_W+2)'(right)
               + (LEVEL_W+2)'(up) + (LEVEL_W+2)'(down);
        prod_c = (LEVEL_W+WEIGHT_W)'(center_weight) * (LEVEL_W+WEIGHT_W)'(center);
        prod_s = (LEVEL_W+WEIGHT_W+2)'(side_weight) * (LEVEL_W+WEIGHT_W+2)'(sides);
        sum    = (LEVEL_W+WEIGHT_W+3)'(prod_c) + (LEVEL_W+WEIGHT_W+3)'(prod_s);
        // border pixels keep their own value
        value  = interior ? sum[LEVEL_W+WEIGHT_W+2:8] : BLUR_W'(center);
        tone_addr = sat_tone(value);
    end

endmodule

/* src/cross_blur_tone_map_unit.sv */
// cross_blur_tone_map_unit: top level, raster position, pipeline control and result sequencing
// depends on cbtm_pkg, cbtm_line_buf, cbtm_blur_lane, cbtm_tone_rom
//
//   port group   direction   handshake            payload
//   in_*         input       in_valid/in_ready    start_of_frame, red/green/blue_level
//   out_*        output      out_valid/out_ready  red/green/blue_out, last_of_run, end_of_frame
//   cfg_*        input       cfg_write            cfg_index, cfg_data
//
// one item per clock outside the last row and while out_ready holds; a result for pixel (x,t)
// leaves once pixel (x,t+1) has passed the registered line buffer reads and tone rom reads.
// items of the last row give two results each, and stage 2 holds such an item, and the input
// stages behind it, until both have left. a stalled output holds its result and stalls them.
// reset clears position, weights and pipeline valids; line buffer contents need no clearing.
`timescale 1ns / 1ps

module cross_blur_tone_map_unit
    import cbtm_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic                   start_of_frame,
    input  logic [LEVEL_W-1:0]     red_level,
    input  logic [LEVEL_W-1:0]     green_level,
    input  logic [LEVEL_W-1:0]     blue_level,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [TONE_W-1:0]      red_out,
    output logic [TONE_W-1:0]      green_out,
    output logic [TONE_W-1:0]      blue_out,
    output logic                   last_of_run,
    output logic                   end_of_frame,
    input  logic                   cfg_write,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    logic [WEIGHT_W-1:0] center_weight_reg;
    logic [WEIGHT_W-1:0] side_weight_reg;
    logic [COL_W-1:0]    col_reg;
    logic [COL_W-1:0]    col_next;
    logic [ROW_W-1:0]    row_reg;
    logic [ROW_W-1:0]    row_next;

    logic                in_accept;
    logic [COL_W-1:0]    pos_x;
    logic [ROW_W-1:0]    pos_r;
    logic [COL_W-1:0]    rd_addr_b;

    logic                s1_valid_reg;
    pixel_t              s1_px_reg;
    logic [COL_W-1:0]    s1_x_reg;
    logic                s1_interior_reg;
    logic                s1_first_reg;
    logic                s1_second_reg;
    logic                s1_eof_reg;
    logic                s1_adv;
    pixel_t              left_hold_reg;

    line_entry_t         line_a;
    pixel_t              line_right;
    line_entry_t         line_wr;

    logic [TONE_ADDR_W-1:0] addr_r;
    logic [TONE_ADDR_W-1:0] addr_g;
    logic [TONE_ADDR_W-1:0] addr_b;
    logic [TONE_W-1:0]      tone_r_a;
    logic [TONE_W-1:0]      tone_r_b;
    logic [TONE_W-1:0]      tone_g_a;
    logic [TONE_W-1:0]      tone_g_b;
    logic [TONE_W-1:0]      tone_b_a;
    logic [TONE_W-1:0]      tone_b_b;

    logic                s2_valid_reg;
    logic                s2_first_pend_reg;
    logic                s2_second_reg;
    logic                s2_eof_reg;
    logic                s2_has_result;
    logic                s2_done;
    logic                s2_free;
    logic                out_fire;

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            center_weight_reg <= CENTER_WEIGHT_RESET;
            side_weight_reg   <= SIDE_WEIGHT_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_CENTER_WEIGHT: center_weight_reg <= cfg_data;
                REG_SIDE_WEIGHT:   side_weight_reg   <= cfg_data;
                default:           ;
            endcase
        end
    end

    // raster position of the item being accepted
    assign in_accept = in_valid && in_ready;
    assign pos_x     = start_of_frame ? '0 : col_reg;
    assign pos_r     = start_of_frame ? '0 : row_reg;
    assign rd_addr_b = (pos_x == COL_W'(FRAME_WIDTH - 1)) ? '0 : pos_x + 1'b1;

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (in_accept)
        begin
            if (pos_x == COL_W'(FRAME_WIDTH - 1))
            begin
                col_next = '0;
                row_next = (pos_r == ROW_W'(FRAME_HEIGHT - 1)) ? '0 : pos_r + 1'b1;
            end
            else
            begin
                col_next = pos_x + 1'b1;
                row_next = pos_r;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // stage 1: line buffer data arrives, blur and write back
    assign s1_adv   = s1_valid_reg && s2_free;
    assign in_ready = !s1_valid_reg || s1_adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (in_accept)
            s1_valid_reg <= 1'b1;
        else if (s1_adv)
            s1_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_px_reg       <= '{red: red_level, green: green_level, blue: blue_level};
            s1_x_reg        <= pos_x;
            s1_interior_reg <= (pos_r >= ROW_W'(2)) && (pos_r <= ROW_W'(FRAME_HEIGHT - 1))
                            && (pos_x >= COL_W'(1)) && (pos_x <= COL_W'(FRAME_WIDTH - 2));
            s1_first_reg    <= (pos_r != '0);
            s1_second_reg   <= (pos_r == ROW_W'(FRAME_HEIGHT - 1));
            s1_eof_reg      <= (pos_r == ROW_W'(FRAME_HEIGHT - 1))
                            && (pos_x == COL_W'(FRAME_WIDTH - 1));
        end
        // left neighbor is the previous item's old current-row value
        if (s1_adv)
            left_hold_reg <= line_a.middle;
    end

    assign line_wr = '{upper: line_a.middle, middle: s1_px_reg};

    cbtm_line_buf u_line_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .rd_en     (in_accept),
        .rd_addr_a (pos_x),
        .rd_addr_b (rd_addr_b),
        .wr_en     (s1_adv),
        .wr_addr   (s1_x_reg),
        .wr_data   (line_wr),
        .rd_data_a (line_a),
        .rd_data_b (line_right)
    );

    cbtm_blur_lane u_blur_r (
        .center_weight (center_weight_reg),
        .side_weight   (side_weight_reg),
        .interior      (s1_interior_reg),
        .center        (line_a.middle.red),
        .left          (left_hold_reg.red),
        .right         (line_right.red),
        .up            (line_a.upper.red),
        .down          (s1_px_reg.red),
        .tone_addr     (addr_r)
    );

    cbtm_blur_lane u_blur_g (
        .center_weight (center_weight_reg),
        .side_weight   (side_weight_reg),
        .interior      (s1_interior_reg),
        .center        (line_a.middle.green),
        .left          (left_hold_reg.green),
        .right         (line_right.green),
        .up            (line_a.upper.green),
        .down          (s1_px_reg.green),
        .tone_addr     (addr_g)
    );

    cbtm_blur_lane u_blur_b (
        .center_weight (center_weight_reg),
        .side_weight   (side_weight_reg),
        .interior      (s1_interior_reg),
        .center        (line_a.middle.blue),
        .left          (left_hold_reg.blue),
        .right         (line_right.blue),
        .up            (line_a.upper.blue),
        .down          (s1_px_reg.blue),
        .tone_addr     (addr_b)
    );

    // port a: row above, port b: the last row's own pixel
    cbtm_tone_rom u_tone_r (
        .clk    (clk),
        .rd_en  (s1_adv),
        .addr_a (addr_r),
        .addr_b (sat_tone(BLUR_W'(s1_px_reg.red))),
        .data_a (tone_r_a),
        .data_b (tone_r_b)
    );

    cbtm_tone_rom u_tone_g (
        .clk    (clk),
        .rd_en  (s1_adv),
        .addr_a (addr_g),
        .addr_b (sat_tone(BLUR_W'(s1_px_reg.green))),
        .data_a (tone_g_a),
        .data_b (tone_g_b)
    );

    cbtm_tone_rom u_tone_b (
        .clk    (clk),
        .rd_en  (s1_adv),
        .addr_a (addr_b),
        .addr_b (sat_tone(BLUR_W'(s1_px_reg.blue))),
        .data_a (tone_b_a),
        .data_b (tone_b_b)
    );

    // stage 2: hand out zero, one or two results
    assign s2_has_result = s2_first_pend_reg || s2_second_reg;
    assign out_valid     = s2_valid_reg && s2_has_result;
    assign out_fire      = out_valid && out_ready;
    assign s2_done       = s2_valid_reg
                        && (!s2_has_result
                            || (out_ready && !(s2_first_pend_reg && s2_second_reg)));
    assign s2_free       = !s2_valid_reg || s2_done;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg      <= 1'b0;
            s2_first_pend_reg <= 1'b0;
            s2_second_reg     <= 1'b0;
            s2_eof_reg        <= 1'b0;
        end
        else if (s1_adv)
        begin
            s2_valid_reg      <= 1'b1;
            s2_first_pend_reg <= s1_first_reg;
            s2_second_reg     <= s1_second_reg;
            s2_eof_reg        <= s1_eof_reg;
        end
        else if (s2_done)
            s2_valid_reg <= 1'b0;
        else if (out_fire)
            s2_first_pend_reg <= 1'b0;
    end

    assign red_out      = s2_first_pend_reg ? tone_r_a : tone_r_b;
    assign green_out    = s2_first_pend_reg ? tone_g_a : tone_g_b;
    assign blue_out     = s2_first_pend_reg ? tone_b_a : tone_b_b;
    assign last_of_run  = !(s2_first_pend_reg && s2_second_reg);
    assign end_of_frame = !s2_first_pend_reg && s2_eof_reg;

endmodule

/* src/cbtm_checker.sv */
// cbtm_checker: port-level checks on the cross blur tone map unit, bound to the top level
// depends on cbtm_pkg and cross_blur_tone_map_unit
`timescale 1ns / 1ps

module cbtm_checker
    import cbtm_pkg::*;
(
    input logic                   clk,
    input logic                   rst_n,
    input logic                   in_valid,
    input logic                   in_ready,
    input logic                   start_of_frame,
    input logic [LEVEL_W-1:0]     red_level,
    input logic [LEVEL_W-1:0]     green_level,
    input logic [LEVEL_W-1:0]     blue_level,
    input logic                   out_valid,
    input logic                   out_ready,
    input logic [TONE_W-1:0]      red_out,
    input logic [TONE_W-1:0]      green_out,
    input logic [TONE_W-1:0]      blue_out,
    input logic                   last_of_run,
    input logic                   end_of_frame,
    input logic                   cfg_write,
    input logic [CFG_INDEX_W-1:0] cfg_index,
    input logic [CFG_DATA_W-1:0]  cfg_data
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(red_out) && $stable(green_out)
            && $stable(blue_out) && $stable(last_of_run) && $stable(end_of_frame))
        else $error("stalled result changed");

    // frame end is always the closing result of its item
    a_eof_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && end_of_frame |-> last_of_run)
        else $error("end_of_frame on a result that is not last");

    // the second result of an item follows straight after the first
    a_second_follows: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !last_of_run |=> out_valid)
        else $error("second result of an item did not follow");

    // while a result pair is stalled, the input does not take fresh items back to back
    a_pair_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !last_of_run && !out_ready |=> !(in_valid && in_ready && out_valid
            && !last_of_run && $past(in_valid && in_ready)))
        else $error("input ran ahead of a pending result pair");

endmodule

bind cross_blur_tone_map_unit cbtm_checker u_cbtm_checker (.*);

/* tb/cbtm_result_checker.sv */
// cbtm_result_checker: watches the pixel, result and register ports of the blur tone map unit,
// predicts every result pixel from its own blur and tone curve, and counts mismatches
// depends on cbtm_pkg for widths, frame size, register indexes and reset weights
`timescale 1ns / 1ps

module cbtm_result_checker
    import cbtm_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    input  logic                   in_ready,
    input  logic                   start_of_frame,
    input  logic [LEVEL_W-1:0]     red_level,
    input  logic [LEVEL_W-1:0]     green_level,
    input  logic [LEVEL_W-1:0]     blue_level,
    input  logic                   out_valid,
    input  logic                   out_ready,
    input  logic [TONE_W-1:0]      red_out,
    input  logic [TONE_W-1:0]      green_out,
    input  logic [TONE_W-1:0]      blue_out,
    input  logic                   last_of_run,
    input  logic                   end_of_frame,
    input  logic                   cfg_write,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    output int                     mismatches,
    output int                     pending_results,
    output int                     pixels_seen,
    output int                     results_seen
);

    typedef struct packed {
        logic [TONE_W-1:0] red;
        logic [TONE_W-1:0] green;
        logic [TONE_W-1:0] blue;
        logic              last;
        logic              eof;
    } toned_pixel_t;

    logic [TONE_W-1:0]   tone_curve [TONE_SIZE];
    logic [WEIGHT_W-1:0] center_w;
    logic [WEIGHT_W-1:0] side_w;
    pixel_t              upper_row  [FRAME_WIDTH];
    pixel_t              middle_row [FRAME_WIDTH];
    pixel_t              left_px;
    int                  col;
    int                  row;
    toned_pixel_t        expected_pixels [$];
    toned_pixel_t        want;

    // 255*(1-e^i) with e = exp(-13/2560) from a five term series, all in fixed point
    initial
    begin
        logic [63:0] t0;
        logic [63:0] t1;
        logic [63:0] t2;
        logic [63:0] t3;
        logic [63:0] t4;
        logic [63:0] e32;
        logic [63:0] p;
        t0  = 64'd1 << 48;
        t1  = t0 * 64'd13 / 64'd2560;
        t2  = t1 * 64'd13 / 64'd5120;
        t3  = t2 * 64'd13 / 64'd7680;
        t4  = t3 * 64'd13 / 64'd10240;
        e32 = (t0 - t1 + t2 - t3 + t4 + (64'd1 << 15)) >> 16;
        p   = 64'd1 << 32;
        for (int i = 0; i < TONE_SIZE; i++)
        begin
            tone_curve[i] = TONE_W'((64'd255 * ((64'd1 << 32) - p)) >> 32);
            p             = (p * e32 + (64'd1 << 31)) >> 32;
        end
    end

    function automatic logic [TONE_W-1:0] shade(input logic [LEVEL_W-1:0] ctr,
                                                input logic [LEVEL_W-1:0] lf,
                                                input logic [LEVEL_W-1:0] rt,
                                                input logic [LEVEL_W-1:0] up,
                                                input logic [LEVEL_W-1:0] dn,
                                                input bit interior);
        logic [31:0] acc;
        acc = 32'(ctr);
        if (interior)
            acc = (32'(center_w) * 32'(ctr)
                   + 32'(side_w) * (32'(lf) + 32'(rt) + 32'(up) + 32'(dn))) >> 8;
        if (acc > TONE_MAX)
            acc = TONE_MAX;
        return tone_curve[acc[TONE_ADDR_W-1:0]];
    endfunction

    // row t leaves while row t+1 arrives; the bottom row also sends itself right after
    task automatic predict_pixel(input logic sof, input pixel_t px);
        pixel_t       mid;
        pixel_t       rt;
        pixel_t       up;
        toned_pixel_t res;
        bit           interior;
        if (sof)
        begin
            col = 0;
            row = 0;
        end
        mid = middle_row[col];
        if (row >= 1)
        begin
            interior  = row >= 2 && col >= 1 && col <= FRAME_WIDTH - 2;
            rt        = interior ? middle_row[col + 1] : '0;
            up        = upper_row[col];
            res.red   = shade(mid.red,   left_px.red,   rt.red,   up.red,   px.red,   interior);
            res.green = shade(mid.green, left_px.green, rt.green, up.green, px.green, interior);
            res.blue  = shade(mid.blue,  left_px.blue,  rt.blue,  up.blue,  px.blue,  interior);
            res.last  = (row != FRAME_HEIGHT - 1);
            res.eof   = 1'b0;
            expected_pixels.push_back(res);
        end
        if (row == FRAME_HEIGHT - 1)
        begin
            res.red   = shade(px.red,   '0, '0, '0, '0, 1'b0);
            res.green = shade(px.green, '0, '0, '0, '0, 1'b0);
            res.blue  = shade(px.blue,  '0, '0, '0, '0, 1'b0);
            res.last  = 1'b1;
            res.eof   = (col == FRAME_WIDTH - 1);
            expected_pixels.push_back(res);
        end
        left_px         = mid;
        upper_row[col]  = mid;
        middle_row[col] = px;
        col++;
        if (col == FRAME_WIDTH)
        begin
            col = 0;
            row++;
            if (row == FRAME_HEIGHT)
                row = 0;
        end
        pixels_seen++;
    endtask

    task automatic check_field(input string name, input int want_v, input int got_v);
        if (want_v != got_v)
        begin
            $display("%0t ns: %s expected %0d actual %0d", $time, name, want_v, got_v);
            mismatches++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            center_w = CENTER_WEIGHT_RESET;
            side_w   = SIDE_WEIGHT_RESET;
            left_px  = '0;
            col      = 0;
            row      = 0;
            for (int i = 0; i < FRAME_WIDTH; i++)
            begin
                upper_row[i]  = '0;
                middle_row[i] = '0;
            end
            expected_pixels.delete();
            pending_results = 0;
            mismatches      = 0;
            pixels_seen     = 0;
            results_seen    = 0;
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    REG_CENTER_WEIGHT: center_w = cfg_data;
                    REG_SIDE_WEIGHT:   side_w   = cfg_data;
                    default: ;
                endcase
            end
            if (in_valid && in_ready)
                predict_pixel(start_of_frame, '{red: red_level, green: green_level,
                                                blue: blue_level});
            if (out_valid && out_ready)
            begin
                if (expected_pixels.size() == 0)
                begin
                    $display("%0t ns: result with no pixel waiting, expected none, %s %0d %0d %0d",
                             $time, "actual", red_out, green_out, blue_out);
                    mismatches++;
                end
                else
                begin
                    want = expected_pixels.pop_front();
                    check_field("red_out",      want.red,   red_out);
                    check_field("green_out",    want.green, green_out);
                    check_field("blue_out",     want.blue,  blue_out);
                    check_field("last_of_run",  want.last,  last_of_run);
                    check_field("end_of_frame", want.eof,   end_of_frame);
                end
                results_seen++;
            end
            pending_results = expected_pixels.size();
        end
    end

endmodule

/* tb/tb_cross_blur_tone_map_unit.sv */
// tb_cross_blur_tone_map_unit: drives pixel frames and weight settings into the blur tone map unit
// under several pacing modes and gives the verdict; depends on cbtm_pkg, cbtm_result_checker
// and the cross_blur_tone_map_unit rtl
`timescale 1ns / 1ps

module tb_cross_blur_tone_map_unit;
    import cbtm_pkg::*;

    typedef enum int {
        PACE_STEADY,
        PACE_SENDER_IDLE,
        PACE_RECEIVER_STALL,
        PACE_BOTH
    } pace_t;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 8;
    localparam int ROTATE_CYCLE   = 250;

    logic                   clk;
    logic                   rst_n;
    logic                   in_valid;
    logic                   in_ready;
    logic                   start_of_frame;
    logic [LEVEL_W-1:0]     red_level;
    logic [LEVEL_W-1:0]     green_level;
    logic [LEVEL_W-1:0]     blue_level;
    logic                   out_valid;
    logic                   out_ready;
    logic [TONE_W-1:0]      red_out;
    logic [TONE_W-1:0]      green_out;
    logic [TONE_W-1:0]      blue_out;
    logic                   last_of_run;
    logic                   end_of_frame;
    logic                   cfg_write;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    int mismatches;
    int pending_results;
    int pixels_seen;
    int results_seen;
    int idle_pct;
    int stall_pct;
    int weight_settings;

    cross_blur_tone_map_unit dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .start_of_frame (start_of_frame),
        .red_level      (red_level),
        .green_level    (green_level),
        .blue_level     (blue_level),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .red_out        (red_out),
        .green_out      (green_out),
        .blue_out       (blue_out),
        .last_of_run    (last_of_run),
        .end_of_frame   (end_of_frame),
        .cfg_write      (cfg_write),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    cbtm_result_checker result_check (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .start_of_frame  (start_of_frame),
        .red_level       (red_level),
        .green_level     (green_level),
        .blue_level      (blue_level),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .red_out         (red_out),
        .green_out       (green_out),
        .blue_out        (blue_out),
        .last_of_run     (last_of_run),
        .end_of_frame    (end_of_frame),
        .cfg_write       (cfg_write),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .mismatches      (mismatches),
        .pending_results (pending_results),
        .pixels_seen     (pixels_seen),
        .results_seen    (results_seen)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            out_ready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    // ends the run when neither channel moves for too long
    initial
    begin
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("timeout: no item moved for %0d cycles", WATCHDOG_LIMIT);
        $display("** cross_blur_tone_map_unit: FAILED **");
        $finish;
    end

    task automatic set_pace(input pace_t pace);
        case (pace)
            PACE_STEADY:         begin idle_pct = 0;  stall_pct = 0;  end
            PACE_SENDER_IDLE:    begin idle_pct = 56; stall_pct = 0;  end
            PACE_RECEIVER_STALL: begin idle_pct = 0;  stall_pct = 56; end
            default:             begin idle_pct = 31; stall_pct = 31; end
        endcase
    endtask

    function automatic logic [LEVEL_W-1:0] random_level();
        logic [LEVEL_W-1:0] v;
        case ($urandom_range(0, 9))
            0:       v = '0;
            1:       v = '1;
            2, 3:    v = LEVEL_W'($urandom);
            default: v = LEVEL_W'($urandom_range(0, 1100));
        endcase
        return v;
    endfunction

    // columns cycle through zero, all ones, the saturation edge, a walking one and a random level
    function automatic logic [LEVEL_W-1:0] pattern_level(input int i, input int ch);
        int                 x;
        logic [LEVEL_W-1:0] v;
        x = i % FRAME_WIDTH;
        case (x % 5)
            0:       v = '0;
            1:       v = '1;
            2:       v = LEVEL_W'(TONE_MAX - 1 + i / FRAME_WIDTH);
            3:       v = LEVEL_W'(1) << ((x / 5 + ch) % LEVEL_W);
            default: v = random_level();
        endcase
        return v;
    endfunction

    // entered and left just after a falling edge
    task automatic push_pixel(input logic sof, input pixel_t px);
        while ($urandom_range(0, 99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid       <= 1'b1;
        start_of_frame <= sof;
        red_level      <= px.red;
        green_level    <= px.green;
        blue_level     <= px.blue;
        do
            @(posedge clk);
        while (!in_ready);
        @(negedge clk);
    endtask

    // hold the sender off until every predicted result has left, then idle on as the extra argument asks
    task automatic settle(input int extra);
        in_valid <= 1'b0;
        @(negedge clk);
        while (pending_results != 0)
            @(negedge clk);
        repeat (extra) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] index,
                             input logic [CFG_DATA_W-1:0] value);
        cfg_write <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        @(negedge clk);
        cfg_write <= 1'b0;
        @(negedge clk);
    endtask

    task automatic set_weights(input logic [CFG_DATA_W-1:0] center,
                               input logic [CFG_DATA_W-1:0] side);
        settle(DRAIN_CYCLES);
        if ($urandom_range(0, 1))
        begin
            write_reg(REG_CENTER_WEIGHT, center);
            write_reg(REG_SIDE_WEIGHT, side);
        end
        else
        begin
            write_reg(REG_SIDE_WEIGHT, side);
            write_reg(REG_CENTER_WEIGHT, center);
        end
        weight_settings++;
    endtask

    task automatic send_pixels(input int count, input bit open_frame, input int restart_permille,
                               input bit patterned, input int rotate_every);
        pixel_t px;
        logic   sof;
        for (int i = 0; i < count; i++)
        begin
            if (rotate_every != 0 && i % rotate_every == 0)
                set_pace(pace_t'((i / rotate_every) % 4));
            if (count > 1 && i == count / 2)
                settle(0);
            sof = (i == 0 && open_frame) || ($urandom_range(0, 999) < restart_permille);
            px.red   = patterned ? pattern_level(i, 0) : random_level();
            px.green = patterned ? pattern_level(i, 1) : random_level();
            px.blue  = patterned ? pattern_level(i, 2) : random_level();
            push_pixel(sof, px);
        end
    endtask

    initial
    begin
        rst_n           = 1'b0;
        in_valid        = 1'b0;
        start_of_frame  = 1'b0;
        red_level       = '0;
        green_level     = '0;
        blue_level      = '0;
        cfg_write       = 1'b0;
        cfg_index       = REG_CENTER_WEIGHT;
        cfg_data        = '0;
        weight_settings = 1;
        set_pace(PACE_STEADY);
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset weights: rows 0 and 1 and the start of row 2, pacing rotating on the way
        send_pixels(2 * FRAME_WIDTH + 20, 1'b0, 0, 1'b1, ROTATE_CYCLE);

        // carry on along row 2 under new weights, extreme ones first
        for (int k = 0; k < 6; k++)
        begin
            case (k)
                0:       set_weights(8'd0, 8'd0);
                1:       set_weights(8'd255, 8'd255);
                2:       set_weights(8'd255, 8'd0);
                3:       set_weights(8'd0, 8'd255);
                default: set_weights(CFG_DATA_W'($urandom), CFG_DATA_W'($urandom));
            endcase
            set_pace(pace_t'(k % 4));
            send_pixels(15, 1'b0, 0, 1'b0, 0);
        end

        // restart the frame part way through a row
        send_pixels(30, 1'b1, 0, 1'b0, 0);

        settle(20);
        $display("covered %0d pixels under %0d weight settings and four pacing modes,",
                 pixels_seen, weight_settings);
        $display("including interior blur rows and a frame restart; %0d results checked",
                 results_seen);
        if (mismatches == 0)
            $display("** cross_blur_tone_map_unit: PASSED **");
        else
            $display("** cross_blur_tone_map_unit: FAILED **");
        $finish;
    end

endmodule

/* files.f */
src/cbtm_pkg.sv
src/cbtm_line_buf.sv
src/cbtm_tone_rom.sv
src/cbtm_blur_lane.sv
src/cross_blur_tone_map_unit.sv
src/cbtm_checker.sv
tb/cbtm_result_checker.sv
tb/tb_cross_blur_tone_map_unit.sv
